// File: rtl/sample_offset_autocalibrator_defines.svh
// ----------------------------------------------------------------------------
// sample_offset_autocalibrator_defines - assertion macros
// Implication checks on the rising clock edge, disabled while reset is high.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_OFFSET_AUTOCALIBRATOR_DEFINES_SVH
`define SAMPLE_OFFSET_AUTOCALIBRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SOAC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define SOAC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SOAC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SOAC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/soac_pkg.sv
// ----------------------------------------------------------------------------
// soac_pkg - shared types and constants
// Field widths, action and register codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package soac_pkg;

  localparam int VAL_W             = 24;
  localparam int ACTION_W          = 2;
  localparam int CFG_INDEX_W       = 2;
  localparam int COLLECTED_W       = 7;
  localparam int FRAC_W            = 16;
  localparam int GAIN_ONE          = 65536;
  localparam int ROUND_HALF        = 32768;
  localparam int VAL_MAX           = 8388607;
  localparam int VAL_MIN           = -8388608;
  localparam int SAMPLE_TARGET_DEF = 100;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE = 2'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fin_write;
    logic mul;
    logic rnd;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/soac_ctrl.sv
// ----------------------------------------------------------------------------
// soac_ctrl - sequencing state machine
// Steps one item through bookkeeping, the average divide on a run end, multiply, round,
// offset/saturate and the output register.
// ----------------------------------------------------------------------------
module soac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  soac_pkg::status_t status,
  output soac_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_RND  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // skip the divide unless this item ends a run
        if (!status.fin) begin
          state_next = S_MUL;
        end else if (status.div_done) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin_write = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.add    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/soac_datapath.sv
// ----------------------------------------------------------------------------
// soac_datapath - calibration registers, run state and arithmetic
// Holds the run accumulator, a restoring serial divider for the average,
// the gain multiplier, rounding, offset/saturation and the output register.
// ----------------------------------------------------------------------------
`include "sample_offset_autocalibrator_defines.svh"

module soac_datapath #(
  parameter int SAMPLE_TARGET = soac_pkg::SAMPLE_TARGET_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic        [soac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [soac_pkg::VAL_W-1:0]       cfg_data,
  input  logic        [soac_pkg::ACTION_W-1:0]    action,
  input  logic signed [soac_pkg::VAL_W-1:0]       reading,
  input  soac_pkg::cmd_t                          cmd,
  output soac_pkg::status_t                       status,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [soac_pkg::VAL_W-1:0]       calibrated_value,
  output logic                                   calibrating,
  output logic        [soac_pkg::COLLECTED_W-1:0] collected,
  output logic                                   finished,
  output logic signed [soac_pkg::VAL_W-1:0]       active_offset
);

  localparam int VAL_W   = soac_pkg::VAL_W;
  localparam int TALLY_W = $clog2(SAMPLE_TARGET + 1);
  localparam int SUM_W   = VAL_W + TALLY_W;
  localparam int CNT_W   = $clog2(SUM_W + 1);
  localparam int PROD_W  = 2 * VAL_W;
  localparam int Q_W     = PROD_W + 1 - soac_pkg::FRAC_W;
  localparam int TOT_W   = Q_W + 1;
  localparam int AVG_W   = VAL_W + 1;
  localparam int DIFF_W  = VAL_W + 2;
  localparam int COLL_W  = soac_pkg::COLLECTED_W;

  localparam logic        [TALLY_W-1:0] TARGET_T = TALLY_W'(SAMPLE_TARGET);
  localparam logic        [CNT_W-1:0]   DIV_STEPS = CNT_W'(SUM_W);
  localparam logic signed [TOT_W-1:0]   SAT_HI   = TOT_W'(soac_pkg::VAL_MAX);
  localparam logic signed [TOT_W-1:0]   SAT_LO   = TOT_W'(soac_pkg::VAL_MIN);
  localparam logic signed [PROD_W:0]    RND_K    = (PROD_W + 1)'(soac_pkg::ROUND_HALF);
  localparam logic signed [VAL_W-1:0]   GAIN_1   = VAL_W'(soac_pkg::GAIN_ONE);

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [TOT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // calibration registers and override
  logic signed [VAL_W-1:0] cal_scale;
  logic signed [VAL_W-1:0] cal_offset;
  logic                    cal_enable;
  logic                    auto_override;
  logic signed [VAL_W-1:0] auto_offset;

  // run state
  logic signed [SUM_W-1:0]   running_sum;
  logic        [TALLY_W-1:0] sample_tally;
  logic                      collecting;
  logic signed [VAL_W-1:0]   reference_level;

  // item in flight
  logic        [soac_pkg::ACTION_W-1:0] item_action;
  logic signed [VAL_W-1:0]              item_reading;
  logic                                 fin;

  // divider
  logic [TALLY_W-1:0] dvs;
  logic [TALLY_W-1:0] rem;
  logic [SUM_W-1:0]   dq;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic [TALLY_W:0]   div_tmp;
  logic [TALLY_W:0]   div_sub;
  logic               div_ge;
  logic [SUM_W-1:0]   sum_mag;

  // arithmetic pipeline
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   rnd_sum;
  logic signed [Q_W-1:0]    q;
  logic signed [TOT_W-1:0]  tot;
  logic signed [VAL_W-1:0]  res;
  logic signed [DIFF_W-1:0] avg_s;
  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] avg_mag;

  logic                    enabled;
  logic signed [VAL_W-1:0] gain_sel;
  logic signed [VAL_W-1:0] offs_sel;
  logic [TALLY_W+COLL_W-1:0] tally_ext;
  logic signed [SUM_W-1:0] reading_ext;

  always_comb begin
    if (auto_override) begin
      enabled  = 1'b1;
      gain_sel = GAIN_1;
      offs_sel = auto_offset;
    end else begin
      enabled  = cal_enable;
      gain_sel = cal_scale;
      offs_sel = cal_offset;
    end
  end

  assign reading_ext = {{(SUM_W - VAL_W){reading[VAL_W-1]}}, reading};
  assign sum_mag     = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  assign div_tmp = {rem, dq[SUM_W-1]};
  assign div_sub = div_tmp - {1'b0, dvs};
  assign div_ge  = !div_sub[TALLY_W];

  assign avg_mag = DIFF_W'(dq[AVG_W-1:0]);
  assign avg_s   = neg ? -$signed(avg_mag) : $signed(avg_mag);
  assign diff    = {{2{reference_level[VAL_W-1]}}, reference_level} - avg_s;

  assign rnd_sum = {prod[PROD_W-1], prod} + RND_K;
  assign tot     = {q[Q_W-1], q} + {{(TOT_W - VAL_W){offs_sel[VAL_W-1]}}, offs_sel};

  assign tally_ext = {{COLL_W{1'b0}}, sample_tally};

  // registers, run bookkeeping and the override
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_scale       <= GAIN_1;
      cal_offset      <= '0;
      cal_enable      <= 1'b0;
      auto_override   <= 1'b0;
      auto_offset     <= '0;
      running_sum     <= '0;
      sample_tally    <= '0;
      collecting      <= 1'b0;
      reference_level <= '0;
      fin             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          soac_pkg::REG_SCALE: begin
            cal_scale     <= cfg_data;
            auto_override <= 1'b0;
          end
          soac_pkg::REG_OFFSET: begin
            cal_offset    <= cfg_data;
            auto_override <= 1'b0;
          end
          soac_pkg::REG_ENABLE: begin
            cal_enable    <= cfg_data[0];
            auto_override <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        fin <= 1'b0;
        case (action)
          soac_pkg::ACT_SAMPLE: begin
            if (collecting) begin
              if (sample_tally < TARGET_T) begin
                running_sum  <= running_sum + reading_ext;
                sample_tally <= sample_tally + TALLY_W'(1);
              end else begin
                fin          <= 1'b1;
                collecting   <= 1'b0;
                sample_tally <= '0;
                running_sum  <= '0;
              end
            end
          end
          soac_pkg::ACT_START: begin
            collecting      <= 1'b1;
            sample_tally    <= '0;
            running_sum     <= '0;
            reference_level <= reading;
          end
          soac_pkg::ACT_STOP: begin
            if (collecting) begin
              fin          <= (sample_tally != '0);
              collecting   <= 1'b0;
              sample_tally <= '0;
              running_sum  <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.fin_write) begin
        auto_offset   <= sat_val({{(TOT_W - DIFF_W){diff[DIFF_W-1]}}, diff});
        auto_override <= 1'b1;
      end
    end
  end

  // serial divider: snapshot sum and tally at load, one quotient bit a step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvs <= sample_tally;
      rem <= '0;
      dq  <= sum_mag;
      neg <= running_sum[SUM_W-1];
    end else if (cmd.div_step) begin
      rem <= div_ge ? div_sub[TALLY_W-1:0] : div_tmp[TALLY_W-1:0];
      dq  <= {dq[SUM_W-2:0], div_ge};
    end
  end

  // item capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action  <= action;
      item_reading <= reading;
    end
    if (cmd.mul) begin
      prod <= item_reading * gain_sel;
    end
    if (cmd.rnd) begin
      q <= rnd_sum[PROD_W:soac_pkg::FRAC_W];
    end
    if (cmd.add) begin
      if (item_action == soac_pkg::ACT_SAMPLE) begin
        res <= enabled ? sat_val(tot) : item_reading;
      end else begin
        res <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      calibrated_value <= res;
      calibrating      <= collecting;
      collected        <= tally_ext[COLL_W-1:0];
      finished         <= fin;
      active_offset    <= enabled ? offs_sel : '0;
    end
  end

  assign status.fin      = fin;
  assign status.div_done = (cnt == DIV_STEPS);
  assign status.out_free = !out_valid || out_ready;

  `SOAC_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready)
  `SOAC_ASSERT_IMP(a_step_bound, clk, rst, cmd.div_step, cnt < DIV_STEPS)
  `SOAC_ASSERT_IMP(a_fin_only_on_end, clk, rst, cmd.fin_write, fin && cnt == DIV_STEPS)
  `SOAC_ASSERT_NXT(a_run_cleared, clk, rst, cmd.load, !fin || (!collecting && sample_tally == '0))

endmodule

// File: rtl/sample_offset_autocalibrator.sv
// ----------------------------------------------------------------------------
// sample_offset_autocalibrator - sample calibration with auto offset
// Items are taken one at a time: a new item is accepted only once the last result is loaded
// into the output register. A run end adds the average divide, one quotient bit per cycle.
// Config writes are never stalled.
// Reset: run state, override and output valid clear; cal regs take reset values.
// ----------------------------------------------------------------------------
module sample_offset_autocalibrator #(
  parameter int SAMPLE_TARGET = soac_pkg::SAMPLE_TARGET_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [soac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [soac_pkg::VAL_W-1:0]       cfg_data,
  // input item channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [soac_pkg::ACTION_W-1:0]    action,
  input  logic signed [soac_pkg::VAL_W-1:0]       reading,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [soac_pkg::VAL_W-1:0]       calibrated_value,
  output logic                                   calibrating,
  output logic        [soac_pkg::COLLECTED_W-1:0] collected,
  output logic                                   finished,
  output logic signed [soac_pkg::VAL_W-1:0]       active_offset
);

  // Flow of one item:
  //   accept  - latch action/reading, update the run (sum, tally, reference),
  //             snapshot sum and tally into the divider for every item
  //   divide  - only on a run end: restoring divide of |sum| by tally,
  //             one quotient bit per cycle, sign reapplied afterward
  //   finish  - offset = reference - average, saturated; force gain 1.0 and
  //             enable until the next register write
  //   mul/rnd - reading * gain, then drop the 16 gain fraction bits, rounding (ties up)
  //   add     - add offset and saturate (raw reading if disabled); zero for start/stop
  //   out     - load the output register once its previous transfer is done
  // A new item is accepted while the previous result still waits in the
  // output register.

  soac_pkg::cmd_t    cmd;
  soac_pkg::status_t status;

  // configuration writes go straight into the registers, so the channel never stalls
  assign cfg_ready = 1'b1;

  soac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  soac_datapath #(
    .SAMPLE_TARGET (SAMPLE_TARGET)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .action           (action),
    .reading          (reading),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .calibrated_value (calibrated_value),
    .calibrating      (calibrating),
    .collected        (collected),
    .finished         (finished),
    .active_offset    (active_offset)
  );

endmodule
